@@ rtl/sorted_priority_queue_defines.svh @@
// Assertion macros used by the checker file.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define SPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SPQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ rtl/spq_pkg.sv @@
package spq_pkg;

    localparam int DEPTH_DEF          = 16;
    localparam int PRIORITY_WIDTH_DEF = 8;
    localparam int VALUE_WIDTH_DEF    = 32;

    localparam int STATUS_WIDTH = 2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    localparam logic [STATUS_WIDTH-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_POPPED    = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [STATUS_WIDTH-1:0] ST_OVERFLOW  = 2'd3;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;
        logic pop;
    } spq_ctl_t;

endpackage

@@ rtl/sorted_priority_queue.sv @@
// A result is registered in the cycle after its input beat is accepted.
// One item per cycle unless m_tready stalls a held result; every cell compares
// and shifts in parallel, so all cells update together on an insert or a pop.
// Reset: aresetn (synchronous, active low) empties the queue and drops any
// pending result; cell contents are not cleared and are never read unless held.
module sorted_priority_queue #(
    parameter int DEPTH          = spq_pkg::DEPTH_DEF,
    parameter int PRIORITY_WIDTH = spq_pkg::PRIORITY_WIDTH_DEF,
    parameter int VALUE_WIDTH    = spq_pkg::VALUE_WIDTH_DEF,
    localparam int CW            = $clog2(DEPTH + 1),
    localparam int IN_W          = ((VALUE_WIDTH + PRIORITY_WIDTH + 7) / 8) * 8,
    localparam int OUT_DATA      = VALUE_WIDTH + PRIORITY_WIDTH + CW,
    localparam int OUT_W         = ((OUT_DATA + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [IN_W-1:0]                 s_tdata,  // value, priority_req, zero pad
    input  logic                            s_tuser,  // command
    // Result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [OUT_W-1:0]                m_tdata,  // popped_value, popped_priority,
                                                      // occupancy, zero pad
    output logic [spq_pkg::STATUS_WIDTH-1:0] m_tuser  // status
);

    // Unpack the input beat.
    logic [VALUE_WIDTH-1:0]    in_value;
    logic [PRIORITY_WIDTH-1:0] in_prio;
    logic                      in_cmd;
    logic                      accept;

    assign in_value = s_tdata[VALUE_WIDTH-1:0];
    assign in_prio  = s_tdata[VALUE_WIDTH +: PRIORITY_WIDTH];
    assign in_cmd   = s_tuser;

    // Output register: accept a new beat whenever the held result leaves
    // this cycle or none is held.
    logic m_valid_reg, m_valid_next;
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Fill count of the chain; cell i holds an entry when i < count.
    logic [CW-1:0] count_reg, count_next;
    logic          full, empty;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    spq_pkg::spq_ctl_t ctl;
    assign ctl.ins = accept && (in_cmd == spq_pkg::CMD_INSERT) && !full;
    assign ctl.pop = accept && (in_cmd == spq_pkg::CMD_POP) && !empty;

    // Chain of cells, cell 0 is the head.
    logic [VALUE_WIDTH-1:0]    cell_value [DEPTH];
    logic [PRIORITY_WIDTH-1:0] cell_prio  [DEPTH];
    logic [DEPTH-1:0]          stay;
    logic [DEPTH-1:0]          occ;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [VALUE_WIDTH-1:0]    left_value, right_value;
        logic [PRIORITY_WIDTH-1:0] left_prio, right_prio;
        logic                      stay_prev;

        assign occ[i] = (count_reg > CW'(i));

        if (i == 0) begin : g_head
            // Nothing ranks ahead of the head: an insert that moves it lands here.
            assign stay_prev  = 1'b1;
            assign left_value = in_value;
            assign left_prio  = in_prio;
        end else begin : g_body
            assign stay_prev  = stay[i-1];
            assign left_value = cell_value[i-1];
            assign left_prio  = cell_prio[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            // The tail slot goes empty on a pop; its contents are don't-care.
            assign right_value = cell_value[i];
            assign right_prio  = cell_prio[i];
        end else begin : g_mid
            assign right_value = cell_value[i+1];
            assign right_prio  = cell_prio[i+1];
        end

        spq_cell #(
            .VALUE_WIDTH    (VALUE_WIDTH),
            .PRIORITY_WIDTH (PRIORITY_WIDTH)
        ) u_cell (
            .aclk        (aclk),
            .ctl         (ctl),
            .occ         (occ[i]),
            .stay_prev   (stay_prev),
            .in_value    (in_value),
            .in_prio     (in_prio),
            .left_value  (left_value),
            .left_prio   (left_prio),
            .right_value (right_value),
            .right_prio  (right_prio),
            .cell_value  (cell_value[i]),
            .cell_prio   (cell_prio[i]),
            .stay        (stay[i])
        );
    end

    // Advance the fill count.
    always_comb begin
        count_next = count_reg;
        if (ctl.ins) begin
            count_next = count_reg + CW'(1);
        end else if (ctl.pop) begin
            count_next = count_reg - CW'(1);
        end
    end

    // Result payload.
    logic [spq_pkg::STATUS_WIDTH-1:0] status_reg, status_next;
    logic [VALUE_WIDTH-1:0]           pop_value_reg, pop_value_next;
    logic [PRIORITY_WIDTH-1:0]        pop_prio_reg, pop_prio_next;
    logic [CW-1:0]                    occ_reg;

    always_comb begin
        pop_value_next = '0;
        pop_prio_next  = '0;
        if (in_cmd == spq_pkg::CMD_INSERT) begin
            status_next = full ? spq_pkg::ST_OVERFLOW : spq_pkg::ST_INSERTED;
        end else if (empty) begin
            status_next = spq_pkg::ST_UNDERFLOW;
        end else begin
            // Return the head entry.
            status_next    = spq_pkg::ST_POPPED;
            pop_value_next = cell_value[0];
            pop_prio_next  = cell_prio[0];
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg    <= status_next;
            pop_value_reg <= pop_value_next;
            pop_prio_reg  <= pop_prio_next;
            occ_reg       <= count_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {{(OUT_W - OUT_DATA){1'b0}}, occ_reg, pop_prio_reg, pop_value_reg};

endmodule

@@ rtl/spq_cell.sv @@
module spq_cell #(
    parameter int VALUE_WIDTH    = spq_pkg::VALUE_WIDTH_DEF,
    parameter int PRIORITY_WIDTH = spq_pkg::PRIORITY_WIDTH_DEF
) (
    input  logic                      aclk,
    input  spq_pkg::spq_ctl_t         ctl,
    input  logic                      occ,
    input  logic                      stay_prev,
    input  logic [VALUE_WIDTH-1:0]    in_value,
    input  logic [PRIORITY_WIDTH-1:0] in_prio,
    input  logic [VALUE_WIDTH-1:0]    left_value,
    input  logic [PRIORITY_WIDTH-1:0] left_prio,
    input  logic [VALUE_WIDTH-1:0]    right_value,
    input  logic [PRIORITY_WIDTH-1:0] right_prio,
    output logic [VALUE_WIDTH-1:0]    cell_value,
    output logic [PRIORITY_WIDTH-1:0] cell_prio,
    output logic                      stay
);

    logic [VALUE_WIDTH-1:0]    value_reg, value_next;
    logic [PRIORITY_WIDTH-1:0] prio_reg, prio_next;

    // Hold the entry when it ranks at or ahead of the incoming one.
    assign stay = occ && (prio_reg <= in_prio);

    always_comb begin
        value_next = value_reg;
        prio_next  = prio_reg;
        if (ctl.ins && !stay) begin
            if (stay_prev) begin
                value_next = in_value;
                prio_next  = in_prio;
            end else begin
                value_next = left_value;
                prio_next  = left_prio;
            end
        end else if (ctl.pop) begin
            value_next = right_value;
            prio_next  = right_prio;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    assign cell_value = value_reg;
    assign cell_prio  = prio_reg;

endmodule

@@ rtl/spq_checker.sv @@
`include "sorted_priority_queue_defines.svh"

module spq_checker #(
    parameter int DEPTH          = spq_pkg::DEPTH_DEF,
    parameter int PRIORITY_WIDTH = spq_pkg::PRIORITY_WIDTH_DEF,
    parameter int VALUE_WIDTH    = spq_pkg::VALUE_WIDTH_DEF,
    localparam int CW            = $clog2(DEPTH + 1),
    localparam int OUT_DATA      = VALUE_WIDTH + PRIORITY_WIDTH + CW,
    localparam int OUT_W         = ((OUT_DATA + 7) / 8) * 8
) (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [OUT_W-1:0]                 m_tdata,
    input logic [spq_pkg::STATUS_WIDTH-1:0] m_tuser
);

    logic [VALUE_WIDTH-1:0]    pop_value;
    logic [PRIORITY_WIDTH-1:0] pop_prio;
    logic [CW-1:0]             occupancy;

    assign pop_value = m_tdata[VALUE_WIDTH-1:0];
    assign pop_prio  = m_tdata[VALUE_WIDTH +: PRIORITY_WIDTH];
    assign occupancy = m_tdata[VALUE_WIDTH + PRIORITY_WIDTH +: CW];

    `SPQ_ASSERT_ALWAYS(a_idle_after_reset, !aresetn |=> !m_tvalid, "result after reset")
    `SPQ_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
    `SPQ_ASSERT(a_zero_payload,
        m_tvalid && m_tuser != spq_pkg::ST_POPPED |-> pop_value == '0 && pop_prio == '0,
        "payload set without pop")
    `SPQ_ASSERT(a_underflow_empty,
        m_tvalid && m_tuser == spq_pkg::ST_UNDERFLOW |-> occupancy == '0,
        "underflow with entries held")
    `SPQ_ASSERT(a_overflow_full,
        m_tvalid && m_tuser == spq_pkg::ST_OVERFLOW |-> occupancy == CW'(DEPTH),
        "overflow below full")

endmodule

bind sorted_priority_queue spq_checker #(
    .DEPTH          (DEPTH),
    .PRIORITY_WIDTH (PRIORITY_WIDTH),
    .VALUE_WIDTH    (VALUE_WIDTH)
) u_spq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
